[design/ps2hp_pkg.sv]
package ps2hp_pkg;

    localparam int unsigned TDATA_W = 16;
    localparam int unsigned TICK_W  = 16;

    localparam logic [1:0] CFG_INHIBIT_TICKS    = 2'd0;
    localparam logic [1:0] CFG_START_HOLD_TICKS = 2'd1;
    localparam logic [1:0] CFG_AUTO_RESEND      = 2'd2;

    localparam logic [TICK_W-1:0] INHIBIT_TICKS_RST    = 16'd100;
    localparam logic [TICK_W-1:0] START_HOLD_TICKS_RST = 16'd100;
    localparam logic              AUTO_RESEND_RST      = 1'b1;

    localparam logic [7:0] RESEND_BYTE = 8'hFE;

    typedef struct packed {
        logic [TICK_W-1:0] inhibit_ticks;
        logic [TICK_W-1:0] start_hold_ticks;
        logic              auto_resend;
    } t_cfg;

    // The last member sits in the lowest bits.
    typedef struct packed {
        logic [7:0] send_byte;
        logic       send_request;
        logic       data_line;
        logic       clk_line;
    } t_item;

    typedef struct packed {
        logic       busy_res;
        logic       tx_done;
        logic       parity_error;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       data_pull_low;
        logic       clk_pull_low;
    } t_result;

    localparam int unsigned ITEM_W   = $bits(t_item);
    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

[design/ps2hp_fsm.sv]
module ps2hp_fsm
    import ps2hp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RX      = 3'd1,
        PH_INHIBIT = 3'd2,
        PH_START   = 3'd3,
        PH_TX      = 3'd4,
        PH_ACK     = 3'd5
    } t_phase;

    t_phase            r_phase,    n_phase;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [8:0]        r_rx_shift, n_rx_shift;
    logic [9:0]        r_tx_shift, n_tx_shift;
    logic              r_prev_clk;
    logic [TICK_W-1:0] r_wait_count, n_wait_count;
    logic              r_resend_pending, n_resend_pending;

    logic              fall;
    logic              rise;
    logic [TICK_W:0]   wait_inc;
    logic [7:0]        send_sel;
    logic [3:0]        tx_idx;
    t_result           res;

    assign fall     = r_prev_clk && !i_item.clk_line;
    assign rise     = !r_prev_clk && i_item.clk_line;
    assign wait_inc = {1'b0, r_wait_count} + {{TICK_W{1'b0}}, 1'b1};
    assign send_sel = r_resend_pending ? RESEND_BYTE : i_item.send_byte;

    always_comb begin
        n_phase          = r_phase;
        n_bit_count      = r_bit_count;
        n_rx_shift       = r_rx_shift;
        n_tx_shift       = r_tx_shift;
        n_wait_count     = r_wait_count;
        n_resend_pending = r_resend_pending;
        res              = '0;

        case (r_phase)
            PH_IDLE: begin
                if (r_resend_pending || i_item.send_request) begin
                    n_resend_pending = 1'b0;
                    n_tx_shift       = {1'b1, ~(^send_sel), send_sel};
                    n_phase          = PH_INHIBIT;
                    n_wait_count     = '0;
                    n_bit_count      = '0;
                end else if (fall) begin
                    n_phase     = PH_RX;
                    n_bit_count = '0;
                end
            end
            PH_RX: begin
                if (fall) begin
                    if (r_bit_count < 4'd9) begin
                        for (int i = 0; i < 9; i++) begin
                            if (r_bit_count == 4'(i)) begin
                                n_rx_shift[i] = i_item.data_line;
                            end
                        end
                        n_bit_count = r_bit_count + 4'd1;
                    end else begin
                        if (^r_rx_shift) begin
                            res.rx_valid = 1'b1;
                        end else begin
                            res.parity_error = 1'b1;
                            if (i_cfg.auto_resend) begin
                                n_resend_pending = 1'b1;
                            end
                        end
                        n_phase     = PH_IDLE;
                        n_bit_count = '0;
                    end
                end
            end
            PH_INHIBIT: begin
                n_wait_count = wait_inc[TICK_W-1:0];
                if (wait_inc >= {1'b0, i_cfg.inhibit_ticks}) begin
                    n_phase      = PH_START;
                    n_wait_count = '0;
                end
            end
            PH_START: begin
                n_wait_count = wait_inc[TICK_W-1:0];
                if (wait_inc >= {1'b0, i_cfg.start_hold_ticks}) begin
                    n_phase      = PH_TX;
                    n_wait_count = '0;
                    n_bit_count  = '0;
                end
            end
            PH_TX: begin
                if (fall) begin
                    if (r_bit_count < 4'd10) begin
                        n_bit_count = r_bit_count + 4'd1;
                    end else begin
                        n_phase = PH_ACK;
                    end
                end
            end
            PH_ACK: begin
                if (rise) begin
                    res.tx_done = 1'b1;
                    n_phase     = PH_IDLE;
                    n_bit_count = '0;
                end
            end
            default: begin
                n_phase     = PH_IDLE;
                n_bit_count = '0;
            end
        endcase

        tx_idx = n_bit_count - 4'd1;
        case (n_phase)
            PH_INHIBIT: begin
                res.clk_pull_low = 1'b1;
            end
            PH_START: begin
                res.clk_pull_low  = 1'b1;
                res.data_pull_low = 1'b1;
            end
            PH_TX: begin
                if (n_bit_count == 4'd0) begin
                    res.data_pull_low = 1'b1;
                end else if (n_bit_count <= 4'd10) begin
                    res.data_pull_low = ~n_tx_shift[tx_idx];
                end
            end
            default: begin
                res.clk_pull_low = 1'b0;
            end
        endcase

        res.rx_byte  = n_rx_shift[7:0];
        res.busy_res = (n_phase != PH_IDLE) || n_resend_pending;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_bit_count      <= '0;
            r_rx_shift       <= '0;
            r_tx_shift       <= '0;
            r_prev_clk       <= 1'b1;
            r_wait_count     <= '0;
            r_resend_pending <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_bit_count      <= n_bit_count;
            r_rx_shift       <= n_rx_shift;
            r_tx_shift       <= n_tx_shift;
            r_prev_clk       <= i_item.clk_line;
            r_wait_count     <= n_wait_count;
            r_resend_pending <= n_resend_pending;
        end
    end

endmodule

[design/ps2_host_port.sv]
// PS/2 host port stepped once per sampling tick: each transfer on the input stream carries one
// sample of the clock and data lines plus an optional send request, and yields exactly one
// result transfer with the open-drain line drives and receive/transmit status. One sample is
// taken every clock cycle in which no result waits or the waiting result is taken; the single
// state register update and the output register set this rate. Timing registers may be written
// over the configuration channel while the port is idle.
module ps2_host_port
    import ps2hp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // clk_line, data_line, send_request, send_byte[7:0], zero padding
    input  logic [TDATA_W-1:0] i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // clk_pull_low, data_pull_low, rx_valid, rx_byte[7:0], parity_error, tx_done,
    // busy_res, zero padding
    output logic [TDATA_W-1:0] o_m_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [TICK_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_item   item;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    step;

    assign item        = t_item'(i_s_tdata[ITEM_W-1:0]);
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign step        = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(TDATA_W-RESULT_W){1'b0}}, r_out};

    ps2hp_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inhibit_ticks    <= INHIBIT_TICKS_RST;
            r_cfg.start_hold_ticks <= START_HOLD_TICKS_RST;
            r_cfg.auto_resend      <= AUTO_RESEND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INHIBIT_TICKS:    r_cfg.inhibit_ticks    <= i_cfg_data;
                CFG_START_HOLD_TICKS: r_cfg.start_hold_ticks <= i_cfg_data;
                CFG_AUTO_RESEND:      r_cfg.auto_resend      <= i_cfg_data[0];
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

endmodule
